FILE: sv/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared codes and types for the 3x3 adjugate matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // entries of one matrix, column-major lane order (lane = col*3 + row)
  localparam int unsigned NUM_ENT = 9;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // operation codes
  localparam logic OP_TRANSPOSE = 1'b1;

  // per-transaction control that rides alongside the divider lanes
  typedef struct packed {
    logic valid;
    logic reject;
    logic det_sat;
  } m3i_ctl_t;

endpackage

FILE: sv/m3i_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_cof
// Cofactor stages: nine pairs of products, then nine differences.
// Products and differences are registered; row 0 of the matrix is delayed alongside.
// ----------------------------------------------------------------------------
module m3i_cof #(
  parameter int unsigned EW = 32
) (
  input  logic                clk_i,
  input  logic signed [EW-1:0] a_i    [3][3],
  output logic signed [2*EW:0] cof_o  [3][3],
  output logic signed [EW-1:0] row0_o [3]
);
  import m3i_pkg::*;

  logic signed [2*EW-1:0] pa_q [3][3];
  logic signed [2*EW-1:0] pb_q [3][3];
  logic signed [2*EW:0]   cof_q [3][3];
  logic signed [EW-1:0]   row0_q [2][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk_i) begin
        pa_q[r][c]  <= a_i[(r+1)%3][(c+1)%3] * a_i[(r+2)%3][(c+2)%3];
        pb_q[r][c]  <= a_i[(r+1)%3][(c+2)%3] * a_i[(r+2)%3][(c+1)%3];
        cof_q[r][c] <= {pa_q[r][c][2*EW-1], pa_q[r][c]}
                     - {pb_q[r][c][2*EW-1], pb_q[r][c]};
      end
      assign cof_o[r][c] = cof_q[r][c];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_row0
    always_ff @(posedge clk_i) begin
      row0_q[0][c] <= a_i[0][c];
      row0_q[1][c] <= row0_q[0][c];
    end
    assign row0_o[c] = row0_q[1][c];
  end

endmodule

FILE: sv/m3i_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det
// Determinant by expansion along row 0, in registered steps: split partial
// products, recombine per column, final three-term sum.
// ----------------------------------------------------------------------------
module m3i_det #(
  parameter int unsigned EW = 32
) (
  input  logic                  clk_i,
  input  logic signed [EW-1:0]  row0_i [3],
  input  logic signed [2*EW:0]  cof_i  [3],
  output logic signed [3*EW+1:0] det_o
);
  import m3i_pkg::*;

  localparam int unsigned CW = 2*EW + 1;
  localparam int unsigned DW = 3*EW + 2;

  logic signed [2*EW:0]  hi_q [3];
  logic signed [2*EW:0]  lo_q [3];
  logic signed [DW-1:0]  t_q  [3];
  logic signed [DW-1:0]  t_d  [3];
  logic signed [DW-1:0]  det_q;

  for (genvar c = 0; c < 3; c++) begin : g_col
    always_ff @(posedge clk_i) begin
      hi_q[c] <= row0_i[c] * $signed(cof_i[c][CW-1:EW]);
      lo_q[c] <= row0_i[c] * $signed({1'b0, cof_i[c][EW-1:0]});
      t_q[c]  <= t_d[c];
    end
    always_comb begin
      t_d[c] = ($signed({{(DW-CW){hi_q[c][CW-1]}}, hi_q[c]}) <<< EW)
             + $signed({{(DW-CW){lo_q[c][CW-1]}}, lo_q[c]});
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= t_q[0] + t_q[1] + t_q[2];
  end

  assign det_o = det_q;

endmodule

FILE: sv/m3i_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div
// Nine-lane pipelined restoring divider with rounding and saturation.
// One quotient bit per stage, shared divisor chain.
// ----------------------------------------------------------------------------
module m3i_div #(
  parameter int unsigned EW = 32,
  parameter int unsigned FW = 16
) (
  input  logic                  clk_i,
  input  logic [2*EW+2*FW:0]    n_i   [m3i_pkg::NUM_ENT],
  input  logic [3*EW+1:0]       d_i,
  input  logic                  neg_i [m3i_pkg::NUM_ENT],
  output logic signed [EW-1:0]  q_o   [m3i_pkg::NUM_ENT],
  output logic                  sat_o [m3i_pkg::NUM_ENT]
);
  import m3i_pkg::*;

  localparam int unsigned CW = 2*EW + 1;
  localparam int unsigned NW = CW + 2*FW;
  localparam int unsigned DW = 3*EW + 2;
  localparam int unsigned QB = EW + 1;
  localparam int unsigned HW = NW - QB;
  localparam int unsigned XW = (HW > DW) ? HW : DW;
  localparam logic [QB:0] LIM_N = {{QB{1'b0}}, 1'b1} << (EW-1);
  localparam logic [QB:0] LIM_P = LIM_N - 1'b1;

  logic [DW-1:0] d_q  [QB+1];
  logic [DW-1:0] r_q  [QB+1][NUM_ENT];
  logic [QB-1:0] nl_q [QB+1][NUM_ENT];
  logic [QB-1:0] qt_q [QB+1][NUM_ENT];
  logic          ng_q [QB+1][NUM_ENT];
  logic          ov_q [QB+1][NUM_ENT];
  logic signed [EW-1:0] q_q   [NUM_ENT];
  logic                 sat_q [NUM_ENT];

  always_ff @(posedge clk_i) begin
    d_q[0] <= d_i;
  end
  for (genvar s = 1; s <= QB; s++) begin : g_dchain
    always_ff @(posedge clk_i) begin
      d_q[s] <= d_q[s-1];
    end
  end

  for (genvar l = 0; l < NUM_ENT; l++) begin : g_lane
    // overflow check and initial partial remainder
    logic [XW-1:0] hx, dx;
    always_comb begin
      hx = XW'(n_i[l][NW-1:QB]);
      dx = XW'(d_i);
    end
    always_ff @(posedge clk_i) begin
      r_q[0][l]  <= hx[DW-1:0];
      nl_q[0][l] <= n_i[l][QB-1:0];
      qt_q[0][l] <= '0;
      ng_q[0][l] <= neg_i[l];
      ov_q[0][l] <= (hx >= dx);
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
      logic [DW:0] rs, rd;
      logic        ge;
      always_comb begin
        rs = {r_q[s-1][l], nl_q[s-1][l][QB-1]};
        ge = (rs >= {1'b0, d_q[s-1]});
        rd = rs - {1'b0, d_q[s-1]};
      end
      always_ff @(posedge clk_i) begin
        r_q[s][l]  <= ge ? rd[DW-1:0] : rs[DW-1:0];
        nl_q[s][l] <= nl_q[s-1][l] << 1;
        qt_q[s][l] <= {qt_q[s-1][l][QB-2:0], ge};
        ng_q[s][l] <= ng_q[s-1][l];
        ov_q[s][l] <= ov_q[s-1][l];
      end
    end

    // round half up on the magnitude, then clamp
    logic          rup, sat;
    logic [QB:0]   qr, lim, mag;
    always_comb begin
      rup = ({r_q[QB][l], 1'b0} >= {1'b0, d_q[QB]});
      qr  = {1'b0, qt_q[QB][l]} + {{QB{1'b0}}, rup};
      lim = ng_q[QB][l] ? LIM_N : LIM_P;
      sat = ov_q[QB][l] || (qr > lim);
      mag = sat ? lim : qr;
    end
    always_ff @(posedge clk_i) begin
      q_q[l]   <= ng_q[QB][l] ? -mag[EW-1:0] : mag[EW-1:0];
      sat_q[l] <= sat;
    end
    assign q_o[l]   = q_q[l];
    assign sat_o[l] = sat_q[l];
  end

endmodule

FILE: sv/matrix3_inverse_adjugate.sv
`timescale 1ns / 1ps
// Output: done_o rises with the registered result and status, and the result
//   is taken at the edge that follows; the restoring divider produces one
//   quotient bit per stage.
// Throughput: one transaction per cycle; busy_o stays low, the receiver cannot stall.
// Reset: rst_ni asynchronous active low clears all valid bits; no transaction
//   in flight survives it.
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate
// 3x3 fixed-point inverse (or transposed inverse) by adjugate over
// determinant, with exact cofactors, rounded quotients and saturation.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate #(
  parameter int unsigned ENTRY_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c0_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c0_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c0_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c2_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c2_i,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c2_i,
  output logic                          done_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c0_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c0_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c0_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c1_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c1_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c1_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c2_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c2_o,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c2_o,
  output logic signed [ENTRY_WIDTH-1:0] determinant_o,
  output logic [1:0]                    status_o
);
  import m3i_pkg::*;

  localparam int unsigned EW = ENTRY_WIDTH;
  localparam int unsigned FW = FRACTION_BITS;
  localparam int unsigned CW = 2*EW + 1;          // cofactor
  localparam int unsigned DW = 3*EW + 2;          // determinant
  localparam int unsigned NW = CW + 2*FW;         // scaled numerator
  localparam int unsigned DL = EW + 4;            // n_q register plus divider (EW+3)
  localparam logic [DW:0] HALF  = {{DW{1'b0}}, 1'b1} << (2*FW-1);
  localparam logic [DW:0] DLIMN = {{DW{1'b0}}, 1'b1} << (EW-1);
  localparam logic [DW:0] DLIMP = DLIMN - 1'b1;

  // The pipeline never stalls, so a start is always taken.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] a_d [3][3];
  logic signed [EW-1:0] a_q [3][3];
  logic [5:0]           fv_q;     // valid, one bit per front stage
  logic [5:0]           fo_q;     // operation, travels with it

  assign a_d[0][0] = in_r0c0_i;
  assign a_d[1][0] = in_r1c0_i;
  assign a_d[2][0] = in_r2c0_i;
  assign a_d[0][1] = in_r0c1_i;
  assign a_d[1][1] = in_r1c1_i;
  assign a_d[2][1] = in_r2c1_i;
  assign a_d[0][2] = in_r0c2_i;
  assign a_d[1][2] = in_r1c2_i;
  assign a_d[2][2] = in_r2c2_i;

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    fo_q <= {fo_q[4:0], operation_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[4:0], start_i && !busy_o};
    end
  end

  // ---------------------------------------------------------------------
  // Cofactors, then determinant
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] cof  [3][3];
  logic signed [EW-1:0] row0 [3];
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] cd_q [3][3][3];   // cofactors held while det forms

  m3i_cof #(.EW(EW)) u_cof (
    .clk_i  (clk_i),
    .a_i    (a_q),
    .cof_o  (cof),
    .row0_o (row0)
  );

  m3i_det #(.EW(EW)) u_det (
    .clk_i  (clk_i),
    .row0_i (row0),
    .cof_i  (cof[0]),
    .det_o  (det)
  );

  always_ff @(posedge clk_i) begin
    cd_q[0] <= cof;
    cd_q[1] <= cd_q[0];
    cd_q[2] <= cd_q[1];
  end

  // ---------------------------------------------------------------------
  // Normalize: sign/magnitude, operand select, determinant field
  // ---------------------------------------------------------------------
  logic              dneg;
  logic [DW-1:0]     dmag;
  logic [DW:0]       tsum, tdet, dlim, dclamp;
  logic              dsat;
  logic [NW-1:0]     n_d   [NUM_ENT];
  logic              neg_d [NUM_ENT];
  logic [NW-1:0]     n_q   [NUM_ENT];
  logic              neg_q [NUM_ENT];
  logic [DW-1:0]     dmag_q;
  m3i_ctl_t          ctl_d;
  logic [EW-1:0]     detf_d;

  always_comb begin
    dneg   = det[DW-1];
    dmag   = dneg ? -det : det;
    tsum   = {1'b0, dmag} + HALF;
    tdet   = tsum >> (2*FW);
    dlim   = dneg ? DLIMN : DLIMP;
    dsat   = (tdet > dlim);
    dclamp = dsat ? dlim : tdet;
    detf_d = dneg ? -dclamp[EW-1:0] : dclamp[EW-1:0];
    ctl_d.valid   = fv_q[5];
    ctl_d.reject  = (det == '0) || ((fo_q[5] == OP_TRANSPOSE) && dneg);
    ctl_d.det_sat = dsat;
  end

  // inverse takes the transposed cofactor, transposed inverse takes it as is
  for (genvar c = 0; c < 3; c++) begin : g_nc
    for (genvar r = 0; r < 3; r++) begin : g_nr
      logic signed [CW-1:0] num;
      logic [CW-1:0]        nmag;
      always_comb begin
        num  = (fo_q[5] == OP_TRANSPOSE) ? cd_q[2][r][c] : cd_q[2][c][r];
        nmag = num[CW-1] ? -num : num;
        n_d[c*3+r]   = {nmag, {(2*FW){1'b0}}};
        neg_d[c*3+r] = num[CW-1] ^ dneg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    neg_q  <= neg_d;
    dmag_q <= dmag;
  end

  // ---------------------------------------------------------------------
  // Divider lanes, with control and determinant field delayed alongside
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] q     [NUM_ENT];
  logic                 q_sat [NUM_ENT];
  m3i_ctl_t             ctl_q  [DL];
  logic [EW-1:0]        detf_q [DL];

  m3i_div #(.EW(EW), .FW(FW)) u_div (
    .clk_i (clk_i),
    .n_i   (n_q),
    .d_i   (dmag_q),
    .neg_i (neg_q),
    .q_o   (q),
    .sat_o (q_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < DL; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    detf_q[0] <= detf_d;
    for (int i = 1; i < DL; i++) begin
      detf_q[i] <= detf_q[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Output register: masking and status
  // ---------------------------------------------------------------------
  m3i_ctl_t             ctl_o;
  logic                 any_sat;
  logic signed [EW-1:0] res_d [NUM_ENT];
  logic signed [EW-1:0] res_q [NUM_ENT];
  logic [1:0]           status_d;
  logic [1:0]           status_q;
  logic [EW-1:0]        det_q;
  logic                 done_q;

  always_comb begin
    ctl_o   = ctl_q[DL-1];
    any_sat = ctl_o.det_sat;
    for (int l = 0; l < NUM_ENT; l++) begin
      any_sat  = any_sat | q_sat[l];
      res_d[l] = ctl_o.reject ? '0 : q[l];
    end
    if (ctl_o.reject) begin
      status_d = STATUS_SINGULAR;
    end else if (any_sat) begin
      status_d = STATUS_SAT;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    status_q <= status_d;
    det_q    <= detf_q[DL-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_o.valid;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign determinant_o = det_q;
  assign out_r0c0_o    = res_q[0];
  assign out_r1c0_o    = res_q[1];
  assign out_r2c0_o    = res_q[2];
  assign out_r0c1_o    = res_q[3];
  assign out_r1c1_o    = res_q[4];
  assign out_r2c1_o    = res_q[5];
  assign out_r0c2_o    = res_q[6];
  assign out_r1c2_o    = res_q[7];
  assign out_r2c2_o    = res_q[8];

endmodule

FILE: sv/m3i_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the matrix inverse pipeline, bound to the top.
// ----------------------------------------------------------------------------
module m3i_checker #(
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [1:0]             status_o,
  input logic [ENTRY_WIDTH-1:0] out_r0c0_o,
  input logic [ENTRY_WIDTH-1:0] out_r1c0_o,
  input logic [ENTRY_WIDTH-1:0] out_r2c0_o,
  input logic [ENTRY_WIDTH-1:0] out_r0c1_o,
  input logic [ENTRY_WIDTH-1:0] out_r1c1_o,
  input logic [ENTRY_WIDTH-1:0] out_r2c1_o,
  input logic [ENTRY_WIDTH-1:0] out_r0c2_o,
  input logic [ENTRY_WIDTH-1:0] out_r1c2_o,
  input logic [ENTRY_WIDTH-1:0] out_r2c2_o
);
  import m3i_pkg::*;

  localparam int unsigned LAT = ENTRY_WIDTH + 11;

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_OK || status_o == STATUS_SINGULAR ||
                status_o == STATUS_SAT))
    else $error("status code out of range");

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_SINGULAR) |->
      (out_r0c0_o == '0 && out_r1c0_o == '0 && out_r2c0_o == '0 &&
       out_r0c1_o == '0 && out_r1c1_o == '0 && out_r2c1_o == '0 &&
       out_r0c2_o == '0 && out_r1c2_o == '0 && out_r2c2_o == '0))
    else $error("singular result not zeroed");

  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |=> !done_o)
    else $error("result strobe right after reset");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without matching start");

endmodule

bind matrix3_inverse_adjugate m3i_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_m3i_checker (.*);
